### hw/rtl/prim_mst_matrix_macros.svh
// Assertion macros for the spanning tree block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef PRIM_MST_MATRIX_MACROS_SVH
`define PRIM_MST_MATRIX_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PMST_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pmst: assertion failed");
`define PMST_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pmst: assertion failed");
`else
`define PMST_ASSERT(name, prop)
`define PMST_ASSERT_NEXT(name, pre, post)
`endif
`endif

### hw/rtl/pmst_pkg.sv
// Shared constants and the result item type of the spanning tree block.
// No dependencies.
package pmst_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 16;
  localparam int unsigned VERTEX_W = 4;
  localparam int unsigned COST_W = 10;
  localparam int unsigned TOTAL_W = 14;
  localparam int unsigned COUNT_W = 5;

  localparam logic [COST_W-1:0]  NO_EDGE      = 10'd999;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = 14'h3FFF;
  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 5'd16;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef struct packed {
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
    logic [COST_W-1:0]   chosen_cost;
    logic [TOTAL_W-1:0]  total_cost;
    logic                is_summary;
    logic                disconnected;
    logic                last;
  } pmst_item_t;

endpackage

### hw/rtl/pmst_cost_mem.sv
// Cost matrix storage: upper triangle of the symmetric matrix, one write and
// one registered read per cycle, swept to the no-edge value after reset. Uses pmst_pkg.
module pmst_cost_mem #(
  parameter int unsigned MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
  localparam int unsigned VW = $clog2(MAX_VERTICES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [VW-1:0]               wr_a_i,
  input  logic [VW-1:0]               wr_b_i,
  input  logic [pmst_pkg::COST_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [VW-1:0]               rd_j_i,
  input  logic [VW-1:0]               rd_k_i,
  output logic [pmst_pkg::COST_W-1:0] rd_data_o,
  output logic                        ready_o
);
  import pmst_pkg::*;

  localparam int unsigned AW = 2 * VW;
  localparam int unsigned DEPTH = 1 << AW;

  logic [COST_W-1:0] mem_q [DEPTH];
  logic [COST_W-1:0] rd_data_q;
  logic [AW-1:0]     clr_addr_q;
  logic              clr_busy_q;

  // Both orientations of a pair share one entry: smaller index first.
  function automatic logic [AW-1:0] pair_addr(logic [VW-1:0] a, logic [VW-1:0] b);
    logic [AW-1:0] addr;
    if (a < b) begin
      addr = {a, b};
    end else begin
      addr = {b, a};
    end
    return addr;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (&clr_addr_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem_q[clr_addr_q] <= NO_EDGE;
    end else if (we_i) begin
      mem_q[pair_addr(wr_a_i, wr_b_i)] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[pair_addr(rd_j_i, rd_k_i)];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = !clr_busy_q;

endmodule

### hw/rtl/pmst_scan.sv
// Prim sequencer: scans the cost matrix one entry a cycle through a single
// compare unit and builds edge and summary items. Uses pmst_pkg and the macro header.
`include "prim_mst_matrix_macros.svh"

module pmst_scan #(
  parameter int unsigned MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF,
  localparam int unsigned VW = $clog2(MAX_VERTICES)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pmst_pkg::COUNT_W-1:0] count_i,
  output logic                         idle_o,
  output logic                         rd_en_o,
  output logic [VW-1:0]                rd_j_o,
  output logic [VW-1:0]                rd_k_o,
  input  logic [pmst_pkg::COST_W-1:0]  rd_data_i,
  output logic                         emit_valid_o,
  input  logic                         emit_ready_i,
  output pmst_pkg::pmst_item_t         emit_item_o
);
  import pmst_pkg::*;

  localparam int unsigned NW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  state_e                  state_q;
  logic [NW-1:0]           n_q;
  logic [NW-1:0]           pass_q;
  logic [VW-1:0]           j_q;
  logic [VW-1:0]           k_q;
  logic [MAX_VERTICES-1:0] visited_q;
  logic [COST_W-1:0]       best_q;
  logic [VW-1:0]           bf_q;
  logic [VW-1:0]           bt_q;
  logic                    found_q;
  logic [TOTAL_W-1:0]      total_q;
  logic                    cmp_valid_q;
  logic [VW-1:0]           cmp_j_q;
  logic [VW-1:0]           cmp_k_q;
  pmst_item_t              item_q;

  logic [NW-1:0]      n_sat;
  logic               take;
  logic               last_k;
  logic               last_j;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_next;

  function automatic pmst_item_t summary_item(logic [TOTAL_W-1:0] total, logic disc);
    pmst_item_t it;
    it.from_vertex  = '0;
    it.to_vertex    = '0;
    it.chosen_cost  = '0;
    it.total_cost   = total;
    it.is_summary   = 1'b1;
    it.disconnected = disc;
    it.last         = 1'b1;
    return it;
  endfunction

  always_comb begin
    if (count_i == '0) begin
      n_sat = NW'(1);
    end else if (32'(count_i) > MAX_VERTICES) begin
      n_sat = NW'(MAX_VERTICES);
    end else begin
      n_sat = NW'(count_i);
    end
  end

  // Shared compare: strict less-than keeps the first edge found on a tie.
  assign take = cmp_valid_q && (rd_data_i < best_q) &&
                visited_q[cmp_j_q] && !visited_q[cmp_k_q];

  assign last_k = (NW'(k_q) == n_q - NW'(1));
  assign last_j = (NW'(j_q) == n_q - NW'(1));

  assign sum        = {1'b0, total_q} + (TOTAL_W + 1)'(best_q);
  assign total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmp_valid_q <= 1'b0;
    end else begin
      cmp_valid_q <= (state_q == ST_SCAN);
      cmp_j_q     <= j_q;
      cmp_k_q     <= k_q;
      if (take) begin
        best_q  <= rd_data_i;
        bf_q    <= cmp_j_q;
        bt_q    <= cmp_k_q;
        found_q <= 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            n_q       <= n_sat;
            visited_q <= MAX_VERTICES'(1);
            total_q   <= '0;
            pass_q    <= NW'(1);
            j_q       <= '0;
            k_q       <= '0;
            best_q    <= NO_EDGE;
            found_q   <= 1'b0;
            if (n_sat == NW'(1)) begin
              item_q  <= summary_item('0, 1'b0);
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (last_k) begin
            k_q <= '0;
            if (last_j) begin
              state_q <= ST_DRAIN;
            end else begin
              j_q <= j_q + VW'(1);
            end
          end else begin
            k_q <= k_q + VW'(1);
          end
        end
        ST_DRAIN: begin
          // last read is compared in this cycle
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (found_q) begin
            visited_q[bt_q]     <= 1'b1;
            total_q             <= total_next;
            item_q.from_vertex  <= VERTEX_W'(bf_q);
            item_q.to_vertex    <= VERTEX_W'(bt_q);
            item_q.chosen_cost  <= best_q;
            item_q.total_cost   <= total_next;
            item_q.is_summary   <= 1'b0;
            item_q.disconnected <= 1'b0;
            item_q.last         <= 1'b0;
          end else begin
            item_q <= summary_item(total_q, 1'b1);
          end
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ready_i) begin
            if (item_q.last) begin
              state_q <= ST_IDLE;
            end else if (pass_q == n_q - NW'(1)) begin
              item_q <= summary_item(total_q, 1'b0);
            end else begin
              pass_q  <= pass_q + NW'(1);
              j_q     <= '0;
              k_q     <= '0;
              best_q  <= NO_EDGE;
              found_q <= 1'b0;
              state_q <= ST_SCAN;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign idle_o       = (state_q == ST_IDLE);
  assign rd_en_o      = (state_q == ST_SCAN);
  assign rd_j_o       = j_q;
  assign rd_k_o       = k_q;
  assign emit_valid_o = (state_q == ST_EMIT);
  assign emit_item_o  = item_q;

  `PMST_ASSERT(a_root_visited, (state_q != ST_IDLE) |-> visited_q[0])
  `PMST_ASSERT(a_cmp_in_scan, cmp_valid_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
  `PMST_ASSERT(a_edge_target_visited, (state_q == ST_EMIT && !item_q.is_summary) |-> visited_q[bt_q])
  `PMST_ASSERT(a_pass_bound, (state_q == ST_SCAN) |-> (pass_q < n_q))

endmodule

### hw/rtl/prim_mst_matrix.sv
// Minimum spanning tree over a loaded cost matrix (Prim's method).
// Input channel: in_valid_i / in_stall_o. Action load writes one undirected
//   edge cost; a new load can follow in the next cycle.
// Action run computes the tree from vertex 0 over the first vertex_count
//   vertices (n, clamped to 1..MAX_VERTICES). Each pass reads the matrix one
//   entry a cycle through the single read port. After the run item is taken,
//   in_stall_o stays high until its summary item enters the output register.
// Output channel: out_valid_o / out_stall_i. One edge item per pass that
//   finds an edge, with the running total, then a summary item (last) with
//   total and disconnected. The decide state of each pass builds its edge item.
// A stalled output item holds in the output register; the sequencer then
//   waits with the next item, and no item is lost.
// Configuration: cfg_valid_i / cfg_ready_o writes vertex_count, always ready.
// Reset: a sweep writes all 2**(2*clog2(MAX_VERTICES)) matrix entries (256 at
//   the default size) to the no-edge cost; in_stall_o stays high until it
//   completes. Uses pmst_pkg, pmst_cost_mem and pmst_scan.
`include "prim_mst_matrix_macros.svh"

module prim_mst_matrix #(
  parameter int unsigned MAX_VERTICES = pmst_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pmst_pkg::COUNT_W-1:0]  cfg_vertex_count_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          in_action_i,
  input  logic [pmst_pkg::VERTEX_W-1:0] in_first_vertex_i,
  input  logic [pmst_pkg::VERTEX_W-1:0] in_second_vertex_i,
  input  logic [pmst_pkg::COST_W-1:0]   in_edge_cost_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pmst_pkg::VERTEX_W-1:0] out_from_vertex_o,
  output logic [pmst_pkg::VERTEX_W-1:0] out_to_vertex_o,
  output logic [pmst_pkg::COST_W-1:0]   out_chosen_cost_o,
  output logic [pmst_pkg::TOTAL_W-1:0]  out_total_cost_o,
  output logic                          out_is_summary_o,
  output logic                          out_disconnected_o,
  output logic                          out_last_o
);
  import pmst_pkg::*;

  localparam int unsigned VW = $clog2(MAX_VERTICES);

  logic [COUNT_W-1:0] vcount_q;
  logic               in_accept;
  logic               load_ok;
  logic               start;
  logic               mem_ready;
  logic               scan_idle;
  logic               rd_en;
  logic [VW-1:0]      rd_j;
  logic [VW-1:0]      rd_k;
  logic [COST_W-1:0]  rd_data;
  logic               emit_valid;
  logic               emit_ready;
  pmst_item_t         emit_item;
  logic               out_valid_q;
  pmst_item_t         out_item_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vcount_q <= cfg_vertex_count_i;
    end
  end

  assign in_stall_o = !(mem_ready && scan_idle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign start      = in_accept && (in_action_i == ACT_RUN);

  // Drop self loops and ends outside the matrix.
  assign load_ok = in_accept && (in_action_i == ACT_LOAD) &&
                   (in_first_vertex_i != in_second_vertex_i) &&
                   (32'(in_first_vertex_i) < MAX_VERTICES) &&
                   (32'(in_second_vertex_i) < MAX_VERTICES);

  pmst_cost_mem #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_cost_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (load_ok),
    .wr_a_i   (VW'(in_first_vertex_i)),
    .wr_b_i   (VW'(in_second_vertex_i)),
    .wr_data_i(in_edge_cost_i),
    .rd_en_i  (rd_en),
    .rd_j_i   (rd_j),
    .rd_k_i   (rd_k),
    .rd_data_o(rd_data),
    .ready_o  (mem_ready)
  );

  pmst_scan #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .count_i     (vcount_q),
    .idle_o      (scan_idle),
    .rd_en_o     (rd_en),
    .rd_j_o      (rd_j),
    .rd_k_o      (rd_k),
    .rd_data_i   (rd_data),
    .emit_valid_o(emit_valid),
    .emit_ready_i(emit_ready),
    .emit_item_o (emit_item)
  );

  // Output register: refill when empty or when the held item is taken.
  assign emit_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_ready) begin
      out_valid_q <= emit_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_valid && emit_ready) begin
      out_item_q <= emit_item;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_from_vertex_o  = out_item_q.from_vertex;
  assign out_to_vertex_o    = out_item_q.to_vertex;
  assign out_chosen_cost_o  = out_item_q.chosen_cost;
  assign out_total_cost_o   = out_item_q.total_cost;
  assign out_is_summary_o   = out_item_q.is_summary;
  assign out_disconnected_o = out_item_q.disconnected;
  assign out_last_o         = out_item_q.last;

  `PMST_ASSERT(a_stall_while_clear, !mem_ready |-> in_stall_o)
  `PMST_ASSERT_NEXT(a_run_stalls, start, in_stall_o)
  `PMST_ASSERT(a_last_is_summary, (out_valid_o && out_last_o) |-> out_is_summary_o)

endmodule

### bench/tb_top.sv
// Self-checking bench for prim_mst_matrix: loads random weighted graphs, runs the tree
// search, and checks every emitted tree edge and summary against an in-bench predictor.
// Depends on pmst_pkg and the prim_mst_matrix RTL only.
`timescale 1ns / 100ps

module tb_top;
  import pmst_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 6000000;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned DRAIN_CYC    = 40;
  localparam int unsigned ITEM_GOAL    = 250;
  localparam int unsigned NV           = MAX_VERTICES_DEF;

  typedef enum logic {REQ_ITEM, REQ_CFG} req_kind_e;

  typedef struct {
    req_kind_e           kind;
    logic                action;
    logic [VERTEX_W-1:0] end_a;
    logic [VERTEX_W-1:0] end_b;
    logic [COST_W-1:0]   wgt;
    logic [COUNT_W-1:0]  cfg_val;
  } req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [COUNT_W-1:0]  cfg_vertex_count_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                in_action_i = ACT_LOAD;
  logic [VERTEX_W-1:0] in_first_vertex_i = '0;
  logic [VERTEX_W-1:0] in_second_vertex_i = '0;
  logic [COST_W-1:0]   in_edge_cost_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [VERTEX_W-1:0] out_from_vertex_o;
  logic [VERTEX_W-1:0] out_to_vertex_o;
  logic [COST_W-1:0]   out_chosen_cost_o;
  logic [TOTAL_W-1:0]  out_total_cost_o;
  logic                out_is_summary_o;
  logic                out_disconnected_o;
  logic                out_last_o;

  prim_mst_matrix dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_vertex_count_i (cfg_vertex_count_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_action_i        (in_action_i),
    .in_first_vertex_i  (in_first_vertex_i),
    .in_second_vertex_i (in_second_vertex_i),
    .in_edge_cost_i     (in_edge_cost_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_from_vertex_o  (out_from_vertex_o),
    .out_to_vertex_o    (out_to_vertex_o),
    .out_chosen_cost_o  (out_chosen_cost_o),
    .out_total_cost_o   (out_total_cost_o),
    .out_is_summary_o   (out_is_summary_o),
    .out_disconnected_o (out_disconnected_o),
    .out_last_o         (out_last_o)
  );

  // Predictor state: mirrored cost matrix and vertex count
  logic [COST_W-1:0]  cost_tab [NV][NV];
  logic [COUNT_W-1:0] vcount_cfg = VCOUNT_RESET;
  pmst_item_t         tree_expect_q[$];

  req_t        req_q[$];
  int unsigned useful_items = 0;
  logic [COUNT_W-1:0] gen_cfg = VCOUNT_RESET;

  int unsigned err_count = 0;
  int unsigned cycles = 0;
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned settle = 0;
  logic        in_quiet = 1'b0;
  logic        out_quiet = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_count(logic [COUNT_W-1:0] c);
    if (c < 1) return 1;
    if (c > NV) return NV;
    return 32'(c);
  endfunction

  // Apply one accepted item to the mirror; a run pushes the expected tree items.
  function automatic void predict_tree(logic act, logic [VERTEX_W-1:0] a,
                                       logic [VERTEX_W-1:0] b, logic [COST_W-1:0] w);
    int unsigned n, pass, j, k, bf, bt, total;
    logic [NV-1:0] seen;
    logic [COST_W-1:0] best;
    bit found, stuck;
    pmst_item_t it;
    if (act == ACT_LOAD) begin
      if (a != b) begin
        cost_tab[a][b] = w;
        cost_tab[b][a] = w;
      end
      return;
    end
    n = clamp_count(vcount_cfg);
    seen = NV'(1);
    total = 0;
    stuck = 1'b0;
    for (pass = 1; pass < n && !stuck; pass++) begin
      best = NO_EDGE;
      found = 1'b0;
      bf = 0;
      bt = 0;
      for (j = 0; j < n; j++) begin
        if (!seen[j]) continue;
        for (k = 0; k < n; k++) begin
          if (cost_tab[j][k] < best && !seen[k]) begin
            best = cost_tab[j][k];
            bf = j;
            bt = k;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        stuck = 1'b1;
      end else begin
        seen[bt] = 1'b1;
        total = total + 32'(best);
        if (total > TOTAL_MAX) total = 32'(TOTAL_MAX);
        it = '{from_vertex: VERTEX_W'(bf), to_vertex: VERTEX_W'(bt), chosen_cost: best,
               total_cost: TOTAL_W'(total), is_summary: 1'b0, disconnected: 1'b0,
               last: 1'b0};
        tree_expect_q.push_back(it);
      end
    end
    it = '{from_vertex: '0, to_vertex: '0, chosen_cost: '0, total_cost: TOTAL_W'(total),
           is_summary: 1'b1, disconnected: stuck, last: 1'b1};
    tree_expect_q.push_back(it);
  endfunction

  function automatic string fmt_item(pmst_item_t it);
    return $sformatf("from=%0d to=%0d cost=%0d total=%0d summ=%0b disc=%0b last=%0b",
                     it.from_vertex, it.to_vertex, it.chosen_cost, it.total_cost,
                     it.is_summary, it.disconnected, it.last);
  endfunction

  function automatic void note_error(string msg);
    if (err_count < 10) $display("mismatch at cycle %0d: %s", cycles, msg);
    err_count++;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    int unsigned r;
    r = $urandom_range(0, 9);
    // small weights force ties between candidate edges
    if (r < 4) return COST_W'($urandom_range(0, 7));
    if (r < 9) return COST_W'($urandom_range(0, 998));
    return COST_W'($urandom_range(999, 1023));
  endfunction

  task automatic add_load(logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b,
                          logic [COST_W-1:0] w);
    req_t r;
    r = '{kind: REQ_ITEM, action: ACT_LOAD, end_a: a, end_b: b, wgt: w, cfg_val: '0};
    req_q.push_back(r);
    useful_items++;
  endtask

  task automatic add_run();
    req_t r;
    r = '{kind: REQ_ITEM, action: ACT_RUN, end_a: VERTEX_W'($urandom_range(0, 15)),
          end_b: VERTEX_W'($urandom_range(0, 15)), wgt: COST_W'($urandom_range(0, 1023)),
          cfg_val: '0};
    req_q.push_back(r);
    useful_items++;
  endtask

  task automatic add_cfg(logic [COUNT_W-1:0] v);
    req_t r;
    r = '{kind: REQ_CFG, action: ACT_LOAD, end_a: '0, end_b: '0, wgt: '0, cfg_val: v};
    req_q.push_back(r);
    gen_cfg = v;
  endtask

  task automatic add_noise();
    add_load(VERTEX_W'($urandom_range(0, 15)), VERTEX_W'($urandom_range(0, 15)),
             COST_W'($urandom_range(0, 1023)));
  endtask

  task automatic build_stimulus();
    int unsigned n, v, u;
    // empty matrix at full size: disconnected on the first pass
    add_run();
    // single vertex, and a count of zero
    add_cfg(1);
    add_run();
    add_cfg(0);
    add_run();
    add_cfg(2);
    add_load(0, 0, 5);
    add_run();
    add_load(1, 0, 998);
    add_run();
    add_load(0, 1, NO_EDGE);
    add_run();
    add_load(0, 1, 1023);
    add_run();
    add_load(1, 0, 0);
    add_run();
    // three-way tie: first found wins
    add_cfg(3);
    add_load(0, 2, 7);
    add_load(2, 1, 7);
    add_load(0, 1, 7);
    add_run();
    add_load(15, 14, 1023);
    add_load(15, 15, 12);
    add_cfg(31);
    add_run();
    add_cfg(17);
    add_run();

    while (useful_items < ITEM_GOAL) begin
      u = $urandom_range(0, 9);
      if ($urandom_range(0, 9) < 7) begin
        if (u < 8) add_cfg(COUNT_W'($urandom_range(2, 8)));
        else if (u == 8) add_cfg(COUNT_W'(NV));
        else add_cfg(COUNT_W'($urandom_range(0, 31)));
      end
      n = clamp_count(gen_cfg);
      if ($urandom_range(0, 4) != 0) begin
        // connected skeleton, extra edges, a little noise
        for (v = 1; v < n; v++) begin
          u = $urandom_range(0, v - 1);
          if ($urandom_range(0, 1)) add_load(VERTEX_W'(v), VERTEX_W'(u), pick_cost());
          else add_load(VERTEX_W'(u), VERTEX_W'(v), pick_cost());
        end
        repeat ($urandom_range(0, n))
          add_load(VERTEX_W'($urandom_range(0, n - 1)), VERTEX_W'($urandom_range(0, n - 1)),
                   pick_cost());
        repeat ($urandom_range(0, 2))
          add_noise();
      end else begin
        repeat ($urandom_range(1, 6))
          add_noise();
      end
      add_run();
    end
  endtask

  // Input and configuration driver
  always @(posedge clk_i) begin : drive_blk
    req_t r;
    logic accepted, cfg_done, nv, ncv;
    if (rst_ni) begin
      accepted = in_valid_i && !in_stall_o;
      cfg_done = cfg_valid_i && cfg_ready_o;
      if (accepted)
        predict_tree(in_action_i, in_first_vertex_i, in_second_vertex_i, in_edge_cost_i);
      if (cfg_done) vcount_cfg = cfg_vertex_count_i;
      nv = in_valid_i && !accepted;
      ncv = cfg_valid_i && !cfg_done;
      if (!nv && !ncv && req_q.size() > 0) begin
        if (req_q[0].kind == REQ_CFG) begin
          // write the register only once the block has gone quiet
          if (tree_expect_q.size() == 0 && settle >= SETTLE_CYC) begin
            r = req_q.pop_front();
            cfg_vertex_count_i <= r.cfg_val;
            ncv = 1'b1;
          end
        end else if (in_gap != 0) begin
          in_gap <= in_gap - 1;
        end else begin
          r = req_q.pop_front();
          in_action_i <= r.action;
          in_first_vertex_i <= r.end_a;
          in_second_vertex_i <= r.end_b;
          in_edge_cost_i <= r.wgt;
          nv = 1'b1;
          in_gap <= in_quiet ? 0 : idle_len();
        end
      end
      in_valid_i <= nv;
      cfg_valid_i <= ncv;
      if (accepted || nv || ncv || out_valid_o || tree_expect_q.size() != 0) settle <= 0;
      else if (settle < SETTLE_CYC) settle <= settle + 1;
      if ($urandom_range(0, 63) == 0) in_quiet <= !in_quiet;
    end
  end

  // Result monitor and output stall generator
  always @(posedge clk_i) begin : mon_blk
    pmst_item_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{from_vertex: out_from_vertex_o, to_vertex: out_to_vertex_o,
                chosen_cost: out_chosen_cost_o, total_cost: out_total_cost_o,
                is_summary: out_is_summary_o, disconnected: out_disconnected_o,
                last: out_last_o};
        if (tree_expect_q.size() == 0) begin
          note_error({"unexpected item ", fmt_item(got)});
        end else begin
          want = tree_expect_q.pop_front();
          if (got !== want)
            note_error({"expected ", fmt_item(want), " got ", fmt_item(got)});
        end
      end
      if (out_gap != 0) begin
        out_stall_i <= 1'b1;
        out_gap <= out_gap - 1;
      end else begin
        out_stall_i <= 1'b0;
        out_gap <= out_quiet ? 0 : idle_len();
      end
      if ($urandom_range(0, 63) == 0) out_quiet <= !out_quiet;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NV; i++)
      for (int j = 0; j < NV; j++)
        cost_tab[i][j] = NO_EDGE;
    build_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (req_q.size() != 0 || in_valid_i || cfg_valid_i || tree_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (tree_expect_q.size() != 0) note_error("expected items left over");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
